[rtl/hts_pkg.sv]
`timescale 1ns / 1ps
package hts_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_MAP_RESOLUTION   = 3'd0,
    REG_GRID_SQUARE_SIZE = 3'd1,
    REG_ORIGIN_X         = 3'd2,
    REG_ORIGIN_Z         = 3'd3,
    REG_HALF_EXTENT      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic        op;
    logic [6:0]  cell_x;
    logic [6:0]  cell_y;
    logic signed [31:0] height_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_z;
  } item_in_t;

  typedef struct packed {
    logic        found;
    logic signed [31:0] height;
  } item_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV_X,
    ST_DIV_Z,
    ST_CHECK,
    ST_READ,
    ST_MAC,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [33:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quotient;
    logic [15:0] frac;
  } div_rsp_t;

endpackage

[rtl/heightfield_triangle_sampler_core.sv]
`timescale 1ns / 1ps
// Channel  | Signals                        | Beat
// item in  | start, busy, item_in           | start high while busy low
// result   | result_valid, item_out         | one cycle, cannot be stalled
// config   | psel penable pwrite paddr ...  | APB access phase, pready high
// A write passes the check and done states; a valid query runs the bit-serial
// divider once per axis, then three serial height store reads.
// After reset a clearing pass of one store entry per cycle (MAX_RESOLUTION
// rounded up to a power of two, then squared) zeroes the store; busy stays high
// during it. Results leave with no backpressure.
module heightfield_triangle_sampler_core #(
  parameter int MAX_RESOLUTION = 128,
  parameter int HEIGHT_BITS    = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hts_pkg::item_in_t item_in,
  output logic              result_valid,
  output hts_pkg::item_out_t item_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hts_pkg::*;

  localparam int CB    = $clog2(MAX_RESOLUTION);
  localparam int AB    = 2 * CB;
  localparam int DEPTH = 1 << AB;

  logic [7:0]  map_resolution;
  logic [30:0] grid_square_size;
  logic signed [31:0] origin_x, origin_z, half_extent;

  logic [31:0] store [DEPTH];
  logic [31:0] rd_data;
  logic [AB-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;

  state_t state, state_next;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [AB:0]  clr_cnt;
  logic [33:0]  px, pz;
  logic [33:0]  cx;
  logic [15:0]  fx;
  logic [33:0]  cz;
  logic [15:0]  fz;
  logic [1:0]   tap;
  logic [1:0]   mac_cnt;
  logic signed [63:0] acc;
  logic signed [31:0] hreg [3];
  logic         upper;
  logic [8:0]   res_eff;
  logic signed [17:0] weight;
  logic signed [31:0] hsel;
  logic signed [63:0] rsum;
  logic signed [47:0] rounded;
  logic [CB-1:0] rx, rz;
  item_in_t    it;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_resolution   <= '0;
      grid_square_size <= 31'd65536;
      origin_x         <= '0;
      origin_z         <= '0;
      half_extent      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_MAP_RESOLUTION:   map_resolution   <= pwdata[7:0];
        REG_GRID_SQUARE_SIZE: grid_square_size <= pwdata[30:0];
        REG_ORIGIN_X:         origin_x         <= pwdata;
        REG_ORIGIN_Z:         origin_z         <= pwdata;
        REG_HALF_EXTENT:      half_extent      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MAP_RESOLUTION:   prdata = {24'b0, map_resolution};
      REG_GRID_SQUARE_SIZE: prdata = {1'b0, grid_square_size};
      REG_ORIGIN_X:         prdata = origin_x;
      REG_ORIGIN_Z:         prdata = origin_z;
      REG_HALF_EXTENT:      prdata = half_extent;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rd_data <= store[rd_addr];
  end

  hts_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign res_eff = (map_resolution > 8'(MAX_RESOLUTION > 255 ? 255 : MAX_RESOLUTION))
                 ? 9'(MAX_RESOLUTION) : {1'b0, map_resolution};
  assign upper = ({1'b0, fx} + {1'b0, fz}) > FRAC_ONE;

  always_comb begin
    rx = cx[CB-1:0];
    rz = cz[CB-1:0];
    case (tap)
      2'd0: if (upper) rx = CB'(cx + 34'd1);
      2'd1: if (upper) begin
              rx = CB'(cx + 34'd1);
              rz = CB'(cz + 34'd1);
            end else rx = CB'(cx + 34'd1);
      default: rz = CB'(cz + 34'd1);
    endcase
    rd_addr = (state == ST_CLEAR) ? clr_cnt[AB-1:0] : {rz, rx};
  end

  always_comb begin
    hsel = hreg[mac_cnt];
    case (mac_cnt)
      2'd0: weight = upper ? 18'(FRAC_ONE - {1'b0, fz})
                           : 18'(FRAC_ONE - {1'b0, fx} - {1'b0, fz});
      2'd1: weight = upper ? 18'({1'b0, fx} + {1'b0, fz} - FRAC_ONE) : 18'({1'b0, fx});
      default: weight = upper ? 18'(FRAC_ONE - {1'b0, fx}) : 18'({1'b0, fz});
    endcase
  end

  assign rsum    = acc + 64'sd32768;
  assign rounded = rsum[63:16];

  always_comb begin
    state_next   = state;
    dreq         = '0;
    wr_en        = 1'b0;
    wr_addr      = {CB'(it.cell_y), CB'(it.cell_x)};
    wr_data      = 32'(signed'(it.height_value[HEIGHT_BITS-1:0]));
    unique case (state)
      ST_IDLE: if (start) state_next = ST_CHECK;
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt[AB-1:0];
        wr_data = '0;
        if (clr_cnt == (AB+1)'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_CHECK: begin
        if (it.op == OP_WRITE) begin
          wr_en = ({7'b0, it.cell_x} < 14'(MAX_RESOLUTION)) &&
                  ({7'b0, it.cell_y} < 14'(MAX_RESOLUTION));
          state_next = ST_DONE;
        end else if (res_eff < 9'd2 || grid_square_size == '0 || px[33] || pz[33]) begin
          state_next = ST_DONE;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = px;
          dreq.divisor  = grid_square_size;
          state_next    = ST_DIV_X;
        end
      end
      ST_DIV_X: if (drsp.done) begin
        dreq.start    = 1'b1;
        dreq.dividend = pz;
        dreq.divisor  = grid_square_size;
        state_next    = ST_DIV_Z;
      end
      ST_DIV_Z: if (drsp.done) state_next = ST_READ;
      ST_READ: begin
        if (cx >= 34'(res_eff - 9'd1) || cz >= 34'(res_eff - 9'd1)) state_next = ST_DONE;
        else if (tap == 2'd3) state_next = ST_MAC;
      end
      ST_MAC: if (mac_cnt == 2'd2) state_next = ST_ROUND;
      ST_ROUND: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      tap          <= '0;
      mac_cnt      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_DONE);
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_IDLE && start) begin
        it <= item_in;
        item_out <= '0;
        tap <= '0;
        mac_cnt <= '0;
        acc <= '0;
      end
      if (state == ST_IDLE && start) begin
        px <= 34'(item_in.world_x) - 34'(origin_x) + 34'(half_extent);
        pz <= 34'(item_in.world_z) - 34'(origin_z) + 34'(half_extent);
      end
      if (state == ST_DIV_X && drsp.done) begin
        cx <= drsp.quotient;
        fx <= drsp.frac;
      end
      if (state == ST_DIV_Z && drsp.done) begin
        cz <= drsp.quotient;
        fz <= drsp.frac;
      end
      if (state == ST_READ) begin
        tap <= tap + 2'd1;
        if (tap != 2'd0) hreg[tap - 2'd1] <= rd_data;
      end
      if (state == ST_MAC) begin
        acc <= acc + 64'(hsel * weight);
        mac_cnt <= mac_cnt + 2'd1;
      end
      if (state == ST_ROUND) begin
        item_out.found <= 1'b1;
        if (rounded > 48'sh7FFFFFFF) item_out.height <= 32'h7FFFFFFF;
        else if (rounded < -48'sh80000000) item_out.height <= 32'h80000000;
        else item_out.height <= rounded[31:0];
      end
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/hts_divider.sv]
`timescale 1ns / 1ps
module hts_divider (
  input  logic              clk,
  input  logic              rst,
  input  hts_pkg::div_req_t req,
  output hts_pkg::div_rsp_t rsp
);
  import hts_pkg::*;

  // Restoring division, one bit a cycle: 34 quotient bits, then 16 fraction bits.
  localparam int STEPS = 50;

  logic [49:0] shreg;
  logic [31:0] rem;
  logic [30:0] dsor;
  logic [5:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem, shreg[49]} - {2'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
        shreg <= {req.dividend, 16'b0};
        rem   <= '0;
        dsor  <= req.divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem   <= trial[31:0];
          shreg <= {shreg[48:0], 1'b1};
        end else begin
          rem   <= {rem[30:0], shreg[49]};
          shreg <= {shreg[48:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = shreg[49:16];
  assign rsp.frac     = shreg[15:0];

endmodule

[rtl/hts_checker.sv]
`timescale 1ns / 1ps
module hts_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input hts_pkg::item_out_t item_out,
  input logic              pready
);
  import hts_pkg::*;

  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    result_valid && !item_out.found |-> item_out.height == '0)
    else $error("miss with nonzero height");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result repeated");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$past(result_valid)) else $error("back to back results");

endmodule

bind heightfield_triangle_sampler_core hts_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .item_out(item_out), .pready(pready)
);

[test/heightfield_triangle_sampler_core_test.sv]
`timescale 1ns / 1ps
module heightfield_triangle_sampler_core_test;
  import hts_pkg::*;

  localparam int RES_MAX = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_in_t item_in = '0;
  logic result_valid;
  item_out_t item_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heightfield_triangle_sampler_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .result_valid(result_valid), .item_out(item_out), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  logic signed [31:0] heights [RES_MAX*RES_MAX];
  logic [7:0] map_res;
  logic [30:0] grid_size;
  logic signed [31:0] org_x, org_z, half_ext;
  item_out_t height_queue [$];
  int fail_count = 0;
  bit hold_off = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit split_axis(input logic signed [63:0] p,
                                    output logic [63:0] idx,
                                    output logic [63:0] frac);
    logic [63:0] r;
    if (p < 0) return 1'b0;
    idx = 64'(p) / 64'(grid_size);
    r = 64'(p) - idx * 64'(grid_size);
    frac = (r << 16) / 64'(grid_size);
    return 1'b1;
  endfunction

  function automatic logic signed [63:0] hgt(input logic [63:0] x, input logic [63:0] y);
    return 64'(heights[(x + y * RES_MAX) % (RES_MAX*RES_MAX)]);
  endfunction

  function automatic item_out_t sample_height(input item_in_t it);
    item_out_t r;
    logic [63:0] res, cx, cz, fx, fz;
    logic signed [63:0] px, pz, s, h;
    r = '0;
    if (it.op == OP_WRITE) begin
      heights[it.cell_x + it.cell_y * RES_MAX] = it.height_value;
      return r;
    end
    res = (map_res > RES_MAX) ? RES_MAX : map_res;
    if (res < 2 || grid_size == 0) return r;
    px = 64'(it.world_x) - 64'(org_x) + 64'(half_ext);
    pz = 64'(it.world_z) - 64'(org_z) + 64'(half_ext);
    if (!split_axis(px, cx, fx) || !split_axis(pz, cz, fz)) return r;
    if (cx >= res - 1 || cz >= res - 1) return r;
    if (fx + fz <= 65536)
      s = $signed(65536 - fx - fz) * hgt(cx, cz) + $signed(fx) * hgt(cx + 1, cz)
        + $signed(fz) * hgt(cx, cz + 1);
    else
      s = $signed(65536 - fz) * hgt(cx + 1, cz) + $signed(fx + fz - 65536) * hgt(cx + 1, cz + 1)
        + $signed(65536 - fx) * hgt(cx, cz + 1);
    h = (s + 32768) >>> 16;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    r.found = 1'b1;
    r.height = h[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    item_out_t want;
    if (!rst && result_valid) begin
      if (height_queue.size() == 0) begin
        $error("unexpected beat found=%0d height=%0d", item_out.found, item_out.height);
        fail_count++;
      end else begin
        want = height_queue.pop_front();
        if (item_out.found !== want.found) begin
          $error("found expected %0d actual %0d", want.found, item_out.found);
          fail_count++;
        end
        if (item_out.height !== want.height) begin
          $error("height expected %0d actual %0d", want.height, item_out.height);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input item_in_t it);
    int gap;
    gap = hold_off ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item_in <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    height_queue.push_back(sample_height(it));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (height_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAP_RESOLUTION: map_res = val[7:0];
      REG_GRID_SQUARE_SIZE: grid_size = val[30:0];
      REG_ORIGIN_X: org_x = val;
      REG_ORIGIN_Z: org_z = val;
      default: half_ext = val;
    endcase
  endtask

  task automatic set_map(input logic [7:0] r, input logic [30:0] g,
                         input logic [31:0] ox, input logic [31:0] oz,
                         input logic [31:0] he);
    drain_results();
    write_reg(REG_MAP_RESOLUTION, 32'(r));
    write_reg(REG_GRID_SQUARE_SIZE, 32'(g));
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_HALF_EXTENT, he);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic item_in_t write_item(input int x, input int y, input logic [31:0] h);
    item_in_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_in_t)-1:0];
    it.op = OP_WRITE;
    it.cell_x = 7'(x);
    it.cell_y = 7'(y);
    it.height_value = h;
    return it;
  endfunction

  function automatic item_in_t query_item(input logic [31:0] wx, input logic [31:0] wz);
    item_in_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_in_t)-1:0];
    it.op = OP_QUERY;
    it.world_x = wx;
    it.world_z = wz;
    return it;
  endfunction

  task automatic test_directed();
    set_map(8'd4, 31'd65536, 32'd0, 32'd0, 32'd0);
    send_item(query_item(32'h8000, 32'h8000));
    send_item(write_item(0, 0, 32'h7fffffff));
    send_item(write_item(1, 0, 32'h80000000));
    send_item(write_item(0, 1, 32'h7fffffff));
    send_item(write_item(1, 1, 32'h7fffffff));
    send_item(write_item(127, 127, 32'h12345678));
    send_item(query_item(32'h0000, 32'h0000));
    send_item(query_item(32'h4000, 32'h4000));
    send_item(query_item(32'hc000, 32'hc000));
    send_item(query_item(32'hffff, 32'h0000));
    send_item(query_item(32'h8000, 32'h8000));
    send_item(query_item(32'hffffffff, 32'h0));
    send_item(query_item(32'h30000, 32'h0));
    send_item(query_item(32'h7fffffff, 32'h80000000));
    set_map(8'd1, 31'd65536, 32'd0, 32'd0, 32'd0);
    send_item(query_item(32'h0, 32'h0));
    set_map(8'd255, 31'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_item(query_item(32'h7fffffff, 32'h7fffffff));
    send_item(query_item(32'h0, 32'h0));
    set_map(8'd200, 31'd1, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_item(query_item(32'h80000000, 32'h80000000));
    set_map(8'd8, 31'd0, 32'd0, 32'd0, 32'd0);
    send_item(query_item(32'h0, 32'h0));
  endtask

  task automatic test_random_phase(input int count, input logic [7:0] r,
                                   input logic [30:0] g, input logic signed [31:0] org);
    int span, x, y;
    set_map(r, g, 32'(org), 32'(-org), 32'(int'(r) * int'(g) / 2));
    span = (r > RES_MAX) ? RES_MAX : ((r < 2) ? 2 : r);
    for (int i = 0; i < count; i++) begin
      x = $urandom_range(0, 127);
      y = $urandom_range(0, 127);
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 3) != 0) begin
          x = $urandom_range(0, span - 1);
          y = $urandom_range(0, span - 1);
        end
        send_item(write_item(x, y, ($urandom_range(0, 7) == 0) ? $urandom
                  : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23))));
      end else if ($urandom_range(0, 9) < 8) begin
        send_item(query_item(32'(org + int'($urandom_range(0, 32'(span) * 32'(g))) - int'(r) * int'(g) / 2),
                  32'(-org + int'($urandom_range(0, 32'(span) * 32'(g))) - int'(r) * int'(g) / 2)));
      end else begin
        send_item(query_item($urandom, $urandom));
      end
    end
  endtask

  task automatic test_pressure();
    hold_off = 1'b1;
    drain_results();
    for (int i = 0; i < 20; i++) send_item(query_item($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18)));
    hold_off = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < RES_MAX*RES_MAX; i++) heights[i] = '0;
    map_res = '0;
    grid_size = 31'd65536;
    org_x = '0;
    org_z = '0;
    half_ext = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(500, 8'd16, 31'd65536, 32'sd0);
    test_random_phase(400, 8'd128, 31'd3000, -32'sd1000000);
    test_pressure();
    test_random_phase(400, 8'd5, 31'd200000, 32'sd70000);
    test_random_phase(200, 8'd2, 31'd1, 32'sd5);
    test_random_phase(250, 8'd150, 31'd5000, 32'sd123456);
    drain_results();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
